@@ hdl/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, codes and a helper function for the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ROUTE_DATA  = 2'd0,
    ROUTE_CLOSE = 2'd1,
    ROUTE_PING  = 2'd2,
    ROUTE_PONG  = 2'd3
  } route_t;

  localparam logic [3:0]  OP_CLOSE     = 4'h8;
  localparam logic [3:0]  OP_PING      = 4'h9;
  localparam logic [3:0]  OP_PONG      = 4'hA;
  localparam logic [6:0]  LEN_EXT16    = 7'd126;
  localparam logic [6:0]  LEN_EXT64    = 7'd127;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
  } token_t;

  function automatic route_t route_of(input logic [3:0] op);
    route_t r;
    case (op)
      OP_CLOSE: r = ROUTE_CLOSE;
      OP_PING:  r = ROUTE_PING;
      OP_PONG:  r = ROUTE_PONG;
      default:  r = ROUTE_DATA;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/websocket_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received WebSocket byte stream and emits unmasked payload beats.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   in_rx_byte
// out_      output     out_valid / out_ready kind, data_byte, opcode, fin,
//                                            route, last_of_frame
// cfg_      input      cfg_wr_en             cfg_wr_data (max payload bytes)
//
// One byte beat is accepted per cycle while the token queue has room.
// A result passes through the token queue and then the output register.
// The queue and the output register let the parser run while the output
// stalls; in_ready drops only when QUEUE_DEPTH tokens are waiting.
// Reset is synchronous and needs no clearing pass; the maximum payload
// returns to 1048576 bytes.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_fin_bit,
  output logic [1:0]  out_route,
  output logic        out_last_of_frame
);

  logic            q_full;
  logic            push;
  wsd_pkg::token_t push_tok;
  logic            pop;
  logic            head_valid;
  wsd_pkg::token_t head_tok;

  assign in_ready = !q_full;

  wsd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (in_valid && in_ready),
    .rx_byte     (in_rx_byte),
    .push        (push),
    .push_tok    (push_tok)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tok   (push_tok),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  wsd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_tok          (head_tok),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_frame_opcode  (out_frame_opcode),
    .out_fin_bit       (out_fin_bit),
    .out_route         (out_route),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

@@ hdl/wsd_front.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer front end
// Parses header, extended length and masking key, and issues one token per
// result into the queue.
// ----------------------------------------------------------------------------
module wsd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data,
  input  logic            fire,
  input  logic [7:0]      rx_byte,
  output logic            push,
  output wsd_pkg::token_t push_tok
);

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [2:0]  ext_r, ext_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        closed_r, closed_nxt;
  logic [31:0] max_r;

  logic        act;
  logic [6:0]  len7;
  logic        len_done;
  logic [63:0] len_val;
  logic        over;
  logic [63:0] acc_sh;
  logic [1:0]  idx_inc;
  logic [31:0] left_dec;
  logic [7:0]  key_sel;

  assign act      = fire && !closed_r;
  assign len7     = rx_byte[6:0];
  assign acc_sh   = {acc_r[55:0], rx_byte};
  assign idx_inc  = idx_r + 2'd1;
  assign left_dec = left_r - 32'd1;

  always_comb begin
    case (idx_r)
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  always_comb begin
    len_done = 1'b0;
    len_val  = acc_sh;
    if (phase_r == wsd_pkg::PH_HDR1 && len7 != wsd_pkg::LEN_EXT16 &&
        len7 != wsd_pkg::LEN_EXT64) begin
      len_done = 1'b1;
      len_val  = {57'd0, len7};
    end else if (phase_r == wsd_pkg::PH_EXT && ext_r == 3'd0) begin
      len_done = 1'b1;
    end
    over = (len_val[63:32] != 32'd0) || (len_val[31:0] > max_r);
  end

  always_comb begin
    phase_nxt = phase_r;
    if (act) begin
      unique case (phase_r)
        wsd_pkg::PH_HDR1, wsd_pkg::PH_EXT: begin
          if (len_done) begin
            if (over) begin
              phase_nxt = wsd_pkg::PH_HDR0;
            end else if (mask_nxt) begin
              phase_nxt = wsd_pkg::PH_KEY;
            end else if (len_val[31:0] == 32'd0) begin
              phase_nxt = wsd_pkg::PH_HDR0;
            end else begin
              phase_nxt = wsd_pkg::PH_DATA;
            end
          end else begin
            phase_nxt = wsd_pkg::PH_EXT;
          end
        end
        wsd_pkg::PH_KEY: begin
          if (idx_inc == 2'd0) begin
            phase_nxt = (left_r == 32'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA;
          end
        end
        wsd_pkg::PH_DATA: begin
          if (left_dec == 32'd0) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
        end
        default: begin
          phase_nxt = wsd_pkg::PH_HDR1;
        end
      endcase
    end
  end

  always_comb begin
    hdr_nxt    = hdr_r;
    mask_nxt   = mask_r;
    acc_nxt    = acc_r;
    ext_nxt    = ext_r;
    left_nxt   = left_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    closed_nxt = closed_r;
    push       = 1'b0;
    push_tok.kind     = wsd_pkg::KIND_DATA;
    push_tok.raw_byte = 8'd0;
    push_tok.key_byte = 8'd0;
    push_tok.opcode   = hdr_r[3:0];
    push_tok.fin      = hdr_r[7];
    push_tok.last     = 1'b1;
    if (act) begin
      unique case (phase_r)
        wsd_pkg::PH_HDR1, wsd_pkg::PH_EXT: begin
          if (phase_r == wsd_pkg::PH_HDR1) begin
            mask_nxt = rx_byte[7];
            if (!len_done) begin
              ext_nxt = (len7 == wsd_pkg::LEN_EXT16) ? 3'd1 : 3'd7;
              acc_nxt = 64'd0;
            end
          end else if (!len_done) begin
            acc_nxt = acc_sh;
            ext_nxt = ext_r - 3'd1;
          end
          if (len_done) begin
            acc_nxt = len_val;
            if (over) begin
              closed_nxt    = 1'b1;
              push          = 1'b1;
              push_tok.kind = wsd_pkg::KIND_ERROR;
            end else begin
              left_nxt = len_val[31:0];
              idx_nxt  = 2'd0;
              if (mask_nxt) begin
                key_nxt = 32'd0;
              end else if (len_val[31:0] == 32'd0) begin
                push          = 1'b1;
                push_tok.kind = wsd_pkg::KIND_EMPTY;
              end
            end
          end
        end
        wsd_pkg::PH_KEY: begin
          key_nxt = {key_r[23:0], rx_byte};
          idx_nxt = idx_inc;
          if (idx_inc == 2'd0 && left_r == 32'd0) begin
            push          = 1'b1;
            push_tok.kind = wsd_pkg::KIND_EMPTY;
          end
        end
        wsd_pkg::PH_DATA: begin
          idx_nxt           = idx_inc;
          left_nxt          = left_dec;
          push              = 1'b1;
          push_tok.kind     = wsd_pkg::KIND_DATA;
          push_tok.raw_byte = rx_byte;
          push_tok.key_byte = mask_r ? key_sel : 8'd0;
          push_tok.last     = (left_dec == 32'd0);
        end
        default: begin
          hdr_nxt = rx_byte;
        end
      endcase
      if (push && push_tok.last && hdr_r[3:0] == wsd_pkg::OP_CLOSE) begin
        closed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_HDR0;
      hdr_r    <= 8'd0;
      mask_r   <= 1'b0;
      acc_r    <= 64'd0;
      ext_r    <= 3'd0;
      left_r   <= 32'd0;
      key_r    <= 32'd0;
      idx_r    <= 2'd0;
      closed_r <= 1'b0;
      max_r    <= wsd_pkg::MAX_PAYLOAD_RESET;
    end else begin
      phase_r  <= phase_nxt;
      hdr_r    <= hdr_nxt;
      mask_r   <= mask_nxt;
      acc_r    <= acc_nxt;
      ext_r    <= ext_nxt;
      left_r   <= left_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
      closed_r <= closed_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
  end

  a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_tok.kind == wsd_pkg::KIND_ERROR |=> closed_r)
    else $error("Oversize error did not close the stream.");

  a_closed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> !push)
    else $error("Token issued on a closed stream.");

  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |=> closed_r)
    else $error("Stream reopened without reset.");

endmodule

@@ hdl/wsd_queue.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer token queue
// Small first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
module wsd_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wsd_pkg::token_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output wsd_pkg::token_t head_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  wsd_pkg::token_t mem [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == DEPTH_C);
  assign head_valid = (cnt_r != '0);
  assign head_tok   = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("Push into a full queue.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("Pop from an empty queue.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("Queue count exceeds its depth.");

endmodule

@@ hdl/wsd_back.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer back end
// Unmasks payload bytes, assigns the route class and holds the result beat.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  wsd_pkg::token_t head_tok,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data_byte,
  output logic [3:0]      out_frame_opcode,
  output logic            out_fin_bit,
  output logic [1:0]      out_route,
  output logic            out_last_of_frame
);

  logic                 vld_r, vld_nxt;
  wsd_pkg::kind_t       kind_r;
  logic [7:0]           data_r;
  logic [3:0]           op_r;
  logic                 fin_r;
  wsd_pkg::route_t      route_r;
  logic                 last_r;

  assign pop = head_valid && (!vld_r || out_ready);

  always_comb begin
    vld_nxt = vld_r;
    if (pop) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= head_tok.kind;
      data_r  <= head_tok.raw_byte ^ head_tok.key_byte;
      op_r    <= head_tok.opcode;
      fin_r   <= head_tok.fin;
      route_r <= wsd_pkg::route_of(head_tok.opcode);
      last_r  <= head_tok.last;
    end
  end

  assign out_valid         = vld_r;
  assign out_kind          = kind_r;
  assign out_data_byte     = data_r;
  assign out_frame_opcode  = op_r;
  assign out_fin_bit       = fin_r;
  assign out_route         = route_r;
  assign out_last_of_frame = last_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !out_ready |=> vld_r && $stable(data_r) && $stable(last_r))
    else $error("Result beat changed while stalled.");

  a_other_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && kind_r != wsd_pkg::KIND_DATA |-> last_r && data_r == 8'd0)
    else $error("Empty or error result not marked last.");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !vld_r || out_ready)
    else $error("Queue popped into an occupied output register.");

endmodule
